// ===== rtl/core/ppb_pkg.sv =====
// ----------------------------------------------------------------------------
// ppb_pkg
// Shared types and constants of the perspective projection block.
// ----------------------------------------------------------------------------
package ppb_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_AB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_CD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_AB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_CD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWW_AB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWW_CD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 3'd7;

  localparam logic [31:0] SCREEN_RESET = 32'd70780800;
  localparam logic [16:0] NEAR_RESET   = 17'd66;

  // One point handed from the front part to the back part.
  typedef struct packed {
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] cw;
    logic               front;
    logic               last;
  } ppb_clip_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_PUSH
  } ppb_fstate_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DIVX, B_DIVY, B_OUT
  } ppb_bstate_t;

endpackage

// ===== rtl/core/ppb_front.sv =====
// ----------------------------------------------------------------------------
// ppb_front
// Accepts points and forms clip x, y and w with one shared multiplier.
// ----------------------------------------------------------------------------
module ppb_front
  import ppb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic               plast,
  input  logic [63:0]        coef [6],
  input  logic [16:0]        near_limit,
  output logic               push,
  output ppb_clip_t          push_data,
  input  logic               full
);

  ppb_fstate_t state, state_next;
  logic [3:0] step;
  logic signed [31:0] xr, yr, zr;
  logic lr;
  logic signed [63:0] acc [3];
  logic signed [63:0] prod;
  logic signed [31:0] c_op, p_op;
  logic [1:0] row;
  logic [1:0] col;
  logic [2:0] creg;

  assign row  = step[3:2];
  assign col  = step[1:0];
  assign creg = {row, col[1]};

  always_comb begin
    logic [63:0] w;
    w = coef[creg];
    c_op = col[0] ? w[63:32] : w[31:0];
    case (col)
      2'd0:    p_op = xr;
      2'd1:    p_op = yr;
      2'd2:    p_op = zr;
      default: p_op = 32'sd1;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= c_op * p_op;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (in_valid) state_next = F_MUL;
      F_MUL:   if (step == 4'd12) state_next = F_PUSH;
      F_PUSH:  if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == F_IDLE);
    push     = (state == F_PUSH) && !full;
  end

  logic signed [63:0] nearq;
  assign nearq = {39'd0, near_limit, 8'd0};
  always_comb begin
    push_data.cx    = acc[0];
    push_data.cy    = acc[1];
    push_data.cw    = acc[2];
    push_data.front = (acc[2] >= nearq) && (acc[2] > 64'sd0);
    push_data.last  = lr;
  end

  // step k issues product k; product k-1 is accumulated.
  logic [3:0] pstep;
  logic [1:0] prow;
  assign pstep = step - 4'd1;
  assign prow  = pstep[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE) step <= '0;
      else if (state == F_MUL) step <= step + 4'd1;
    end
    if (state == F_IDLE && in_valid) begin
      xr <= px; yr <= py; zr <= pz; lr <= plast;
      acc[0] <= '0; acc[1] <= '0; acc[2] <= '0;
    end
    if (state == F_MUL && step != 4'd0) begin
      if (pstep[1:0] == 2'd3) acc[prow] <= acc[prow] + prod;
      else acc[prow] <= acc[prow] + (prod >>> 16);
    end
  end

endmodule

// ===== rtl/core/ppb_queue.sv =====
// ----------------------------------------------------------------------------
// ppb_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module ppb_queue
  import ppb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ppb_clip_t wdata,
  output logic      full,
  input  logic      pop,
  output ppb_clip_t rdata,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  ppb_clip_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= wdata;
  end

endmodule

// ===== rtl/core/ppb_back.sv =====
// ----------------------------------------------------------------------------
// ppb_back
// Divides to pixels with a bit-serial divider and keeps the group box.
// ----------------------------------------------------------------------------
module ppb_back
  import ppb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  ppb_clip_t        item,
  output logic             pop,
  input  logic [31:0]      screen_size,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [98:0]      out_data
);

  ppb_bstate_t state, state_next;
  ppb_clip_t cur;
  logic [6:0] bitn;
  logic [80:0] num;
  logic [65:0] rem;
  logic [19:0] q;
  logic sat, neg;
  logic signed [15:0] sx, sy;
  logic signed [15:0] min_x, max_x, min_y, max_y;
  logic all_in_front, group_start;
  logic div_last;
  logic obuf_full;

  assign div_last = (bitn == 7'd0);

  // Remainder step of the long division; the dividend has at most 81 bits.
  logic [65:0] rem_sh;
  logic [65:0] dv;
  logic ge;
  assign dv     = {1'b0, cur.cw[63:0], 1'b0};
  assign rem_sh = {rem[64:0], num[80]};
  assign ge     = rem_sh >= dv;

  // Saturated signed pixel from the quotient.
  logic signed [15:0] pix;
  always_comb begin
    logic [19:0] qf;
    qf = q;
    if (ge && bitn < 7'd20) qf[bitn[4:0]] = 1'b1;
    if (neg) pix = (sat || qf > 20'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, qf}));
    else     pix = (sat || qf > 20'd32767) ? 16'sd32767 : 16'(qf);
  end

  function automatic logic [80:0] mag_scale(input logic signed [63:0] n,
                                            input logic [15:0] s);
    logic [64:0] m;
    m = n[63] ? 65'(-{n[63], n}) : {1'b0, n};
    return 81'(m * s);
  endfunction

  logic signed [64:0] nx, ny;
  assign nx = {item.cw[63], item.cw} + {item.cx[63], item.cx};
  assign ny = {cur.cw[63], cur.cw} - {cur.cy[63], cur.cy};

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!empty) state_next = B_DIVX;
      B_DIVX:  if (!cur.front) state_next = B_OUT;
               else if (div_last) state_next = B_DIVY;
      B_DIVY:  if (div_last) state_next = B_OUT;
      B_OUT:   if (!obuf_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == B_IDLE) && !empty;
  end

  logic signed [15:0] nminx, nmaxx, nminy, nmaxy;
  always_comb begin
    if (group_start) begin
      nminx = sx; nmaxx = sx; nminy = sy; nmaxy = sy;
    end else begin
      nminx = (sx < min_x) ? sx : min_x;
      nmaxx = (sx > max_x) ? sx : max_x;
      nminy = (sy < min_y) ? sy : min_y;
      nmaxy = (sy > max_y) ? sy : max_y;
    end
  end

  logic ngs, nall;
  assign ngs  = group_start && !cur.front;
  assign nall = all_in_front && cur.front;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      group_start <= 1'b1; all_in_front <= 1'b1;
      min_x <= '0; max_x <= '0; min_y <= '0; max_y <= '0;
      obuf_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_OUT && !obuf_full) begin
        obuf_full <= 1'b1;
        if (cur.front) begin
          min_x <= nminx; max_x <= nmaxx; min_y <= nminy; max_y <= nmaxy;
        end
        group_start <= cur.last ? 1'b1 : ngs;
        all_in_front <= cur.last ? 1'b1 : nall;
      end else if (out_valid && out_ready) begin
        obuf_full <= 1'b0;
      end
    end
    if (pop) begin
      cur <= item;
    end
    if (state == B_IDLE) begin
      bitn <= 7'd80; rem <= '0; q <= '0; sat <= 1'b0;
      num <= mag_scale(nx[63:0], screen_size[15:0]);
      neg <= nx[64];
    end else if ((state == B_DIVX || state == B_DIVY) && !div_last) begin
      rem <= ge ? rem_sh - dv : rem_sh;
      num <= {num[79:0], 1'b0};
      if (ge && bitn >= 7'd20) sat <= 1'b1;
      if (ge && bitn < 7'd20) q[bitn[4:0]] <= 1'b1;
      bitn <= bitn - 7'd1;
    end else if (state == B_DIVX && div_last) begin
      rem <= '0; q <= '0; sat <= 1'b0; bitn <= 7'd80;
      num <= mag_scale(ny[63:0], screen_size[31:16]);
      neg <= ny[64];
    end
    if (state == B_DIVX && !cur.front) begin
      sx <= '0; sy <= '0;
    end else if (state == B_DIVX && div_last) begin
      sx <= pix;
    end else if (state == B_DIVY && div_last) begin
      sy <= pix;
    end
    if (state == B_OUT && !obuf_full) begin
      out_data[15:0]  <= sx;
      out_data[31:16] <= sy;
      out_data[32]    <= cur.front;
      out_data[33]    <= cur.last;
      if (cur.last && !ngs) begin
        out_data[34]     <= nall;
        out_data[50:35]  <= cur.front ? nminx : min_x;
        out_data[66:51]  <= cur.front ? nminy : min_y;
        out_data[82:67]  <= cur.front ? 16'(nmaxx - nminx) : 16'(max_x - min_x);
        out_data[98:83]  <= cur.front ? 16'(nmaxy - nminy) : 16'(max_y - min_y);
      end else begin
        out_data[98:34] <= '0;
      end
    end
  end

  assign out_valid = obuf_full;

  assert property (@(posedge clk) disable iff (rst) !(state == B_DIVY && !cur.front))
    else $error("divide y behind camera");
  assert property (@(posedge clk) disable iff (rst) pop |-> state == B_IDLE)
    else $error("pop while busy");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while waiting");

endmodule

// ===== rtl/core/perspective_project_and_bound.sv =====
// ----------------------------------------------------------------------------
// perspective_project_and_bound
// Projects Q16.16 points to screen pixels and reports a per-group box.
// ----------------------------------------------------------------------------
// The front part accepts a point, lets one shared 32x32 multiplier form clip
// x, y and w, and pushes the result into the queue once it is not full. An
// in-front point then passes through the back part in order: it is taken
// from the queue, goes through the two bit-serial divisions, and is loaded
// into the output register once that is free. The back part therefore sets
// the rate for in-front points. A point behind the camera skips both divisions,
// so a run of such points is limited by the front part. A two-entry queue
// lets the front part take the next point while the back part divides.
module perspective_project_and_bound
  import ppb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // point_x, point_y, point_z
  input  logic         s_axis_tlast,  // group_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // screen_x, screen_y, in_front, box_done, box_ok, box_left, box_bottom,
  // box_width, box_height, zero fill
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] coef [6];
  logic [31:0] screen_size;
  logic [16:0] near_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) coef[i] <= '0;
      screen_size <= SCREEN_RESET;
      near_limit  <= NEAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN: screen_size <= cfg_data[31:0];
        REG_NEAR:   near_limit  <= cfg_data[16:0];
        default:    coef[cfg_index] <= cfg_data;
      endcase
    end
  end

  logic push, full, pop, empty;
  ppb_clip_t qin, qout;
  logic [98:0] od;

  ppb_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]), .pz(s_axis_tdata[95:64]),
    .plast(s_axis_tlast), .coef, .near_limit,
    .push, .push_data(qin), .full
  );

  ppb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .wdata(qin), .full, .pop, .rdata(qout), .empty
  );

  ppb_back u_back (
    .clk, .rst, .empty, .item(qout), .pop, .screen_size,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
  );

  assign m_axis_tdata = {5'b00000, od};

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of perspective_project_and_bound.
// A directed table, then random groups under several matrix, screen and near
// limit settings, are streamed with random gaps on both sides. Each accepted
// item is predicted by a local projection and box model or, if typed, by the
// table; every result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
  import ppb_pkg::*;

  typedef struct packed {
    logic [15:0] box_height;
    logic [15:0] box_width;
    logic [15:0] box_bottom;
    logic [15:0] box_left;
    logic        box_ok;
    logic        box_done;
    logic        in_front;
    logic [15:0] screen_y;
    logic [15:0] screen_x;
  } pixel_res_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        last;
    logic        typed;
    pixel_res_t  res;
  } point_row_t;

  localparam longint  LIMIT = 3000000;
  localparam logic [31:0] ONE = 32'h0100_0000;

  logic         clk = 0, rst = 1;
  logic         s_axis_tvalid = 0, s_axis_tlast = 0;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  logic [63:0]  mat_regs [8];
  logic [15:0]  box_min_x, box_max_x, box_min_y, box_max_y;
  logic         group_all_front, group_fresh;
  pixel_res_t   pending_pixels [$];
  int           mismatches = 0;
  bit           quiet = 0;
  longint       cycles = 0;

  perspective_project_and_bound i_dut (.*);

  initial begin
    forever begin
      #5 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  function automatic longint row_dot(logic [63:0] ab, logic [63:0] cd,
                                     longint px, longint py, longint pz);
    longint s;
    s = (longint'(signed'(ab[31:0])) * px) >>> 16;
    s += (longint'(signed'(ab[63:32])) * py) >>> 16;
    s += (longint'(signed'(cd[31:0])) * pz) >>> 16;
    return s + longint'(signed'(cd[63:32]));
  endfunction

  function automatic logic [15:0] pixel_div(longint n, longint d, logic [15:0] size);
    logic [127:0] mag, q;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    q = (mag * size) / 128'(d);
    if (n < 0) return (q > 32768) ? 16'h8000 : -q[15:0];
    return (q > 32767) ? 16'h7fff : q[15:0];
  endfunction

  function automatic pixel_res_t project_point(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic last);
    pixel_res_t r;
    longint px, py, pz, cx, cy, cw, nearq;
    logic front;
    r = '0;
    px = longint'(signed'(x));
    py = longint'(signed'(y));
    pz = longint'(signed'(z));
    cx = row_dot(mat_regs[REG_ROW0_AB], mat_regs[REG_ROW0_CD], px, py, pz);
    cy = row_dot(mat_regs[REG_ROW1_AB], mat_regs[REG_ROW1_CD], px, py, pz);
    cw = row_dot(mat_regs[REG_ROWW_AB], mat_regs[REG_ROWW_CD], px, py, pz);
    nearq = longint'(mat_regs[REG_NEAR][16:0]) << 8;
    front = (cw >= nearq) && (cw > 0);
    if (front) begin
      r.screen_x = pixel_div(cw + cx, 2 * cw, mat_regs[REG_SCREEN][15:0]);
      r.screen_y = pixel_div(cw - cy, 2 * cw, mat_regs[REG_SCREEN][31:16]);
      r.in_front = 1;
      if (group_fresh) begin
        box_min_x = r.screen_x; box_max_x = r.screen_x;
        box_min_y = r.screen_y; box_max_y = r.screen_y;
        group_fresh = 0;
      end else begin
        if ($signed(r.screen_x) < $signed(box_min_x)) box_min_x = r.screen_x;
        if ($signed(r.screen_x) > $signed(box_max_x)) box_max_x = r.screen_x;
        if ($signed(r.screen_y) < $signed(box_min_y)) box_min_y = r.screen_y;
        if ($signed(r.screen_y) > $signed(box_max_y)) box_max_y = r.screen_y;
      end
    end else begin
      group_all_front = 0;
    end
    if (last) begin
      r.box_done = 1;
      if (!group_fresh) begin
        r.box_ok     = group_all_front;
        r.box_left   = box_min_x;
        r.box_bottom = box_min_y;
        r.box_width  = box_max_x - box_min_x;
        r.box_height = box_max_y - box_min_y;
      end
      group_fresh = 1;
      group_all_front = 1;
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    mat_regs[idx] = (idx == REG_SCREEN) ? {32'd0, val[31:0]} :
                    (idx == REG_NEAR) ? {47'd0, val[16:0]} : val;
  endtask

  task automatic wait_idle();
    cfg_we <= 0;
    s_axis_tvalid <= 0;
    wait (pending_pixels.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic last, logic typed, pixel_res_t res);
    pixel_res_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    p = project_point(x, y, z, last);
    pending_pixels.push_back(typed ? res : p);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  task automatic random_setting();
    logic [31:0] scr;
    write_reg(REG_ROW0_AB, {rand_coef(), rand_coef()});
    write_reg(REG_ROW0_CD, {rand_coef(), rand_coef()});
    write_reg(REG_ROW1_AB, {rand_coef(), rand_coef()});
    write_reg(REG_ROW1_CD, {rand_coef(), rand_coef()});
    // w mostly follows z with a positive offset so that most points land in front.
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_ROWW_AB, {rand_coef(), rand_coef()});
    else
      write_reg(REG_ROWW_AB, {$urandom_range(0, 32'h0010_0000),
                              $urandom_range(0, 32'h0010_0000)});
    write_reg(REG_ROWW_CD, {32'(ONE * $urandom_range(1, 40)), ONE});
    case ($urandom_range(0, 4))
      0: scr = 32'd0;
      1: scr = 32'hffff_ffff;
      2: scr = $urandom;
      default: scr = {16'($urandom_range(1, 2160)), 16'($urandom_range(1, 3840))};
    endcase
    write_reg(REG_SCREEN, {$urandom, scr});
    case ($urandom_range(0, 3))
      0: write_reg(REG_NEAR, 64'd0);
      1: write_reg(REG_NEAR, 64'h1_0000);
      default: write_reg(REG_NEAR, {$urandom, $urandom});
    endcase
  endtask

  function automatic logic check_field(string name, logic [15:0] e, logic [15:0] a);
    if (e === a) return 0;
    if (mismatches < 10)
      $display("mismatch in %s: expected %h, got %h", name, e, a);
    mismatches++;
    return 1;
  endfunction

  always @(posedge clk) begin
    pixel_res_t act, e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act = m_axis_tdata[98:0];
      if (pending_pixels.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %h", act);
        mismatches++;
      end else begin
        e = pending_pixels.pop_front();
        void'(check_field("screen_x", e.screen_x, act.screen_x));
        void'(check_field("screen_y", e.screen_y, act.screen_y));
        void'(check_field("in_front", e.in_front, act.in_front));
        void'(check_field("box_done", e.box_done, act.box_done));
        void'(check_field("box_ok", e.box_ok, act.box_ok));
        void'(check_field("box_left", e.box_left, act.box_left));
        void'(check_field("box_bottom", e.box_bottom, act.box_bottom));
        void'(check_field("box_width", e.box_width, act.box_width));
        void'(check_field("box_height", e.box_height, act.box_height));
        void'(check_field("zero fill", 16'd0, 16'(m_axis_tdata[103:99])));
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (quiet) begin
        m_axis_tready <= 1;
        @(posedge clk);
      end else begin
        m_axis_tready <= $urandom_range(0, 2) != 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    point_row_t dir [$];
    pixel_res_t r;
    int n;
    mat_regs = '{default: '0};
    mat_regs[REG_SCREEN] = {32'd0, SCREEN_RESET};
    mat_regs[REG_NEAR] = {47'd0, NEAR_RESET};
    group_fresh = 1;
    group_all_front = 1;

    // Reset matrix is all zero: w is zero, every point is behind the camera.
    r = '0;
    dir.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 0, 1, r});
    r.box_done = 1;
    dir.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1, 1, r});
    // Camera looking along z: x and y pass through, w equals z.
    r = '0;
    r.screen_x = 16'd960; r.screen_y = 16'd540; r.in_front = 1;
    dir.push_back('{32'h0, 32'h0, ONE >> 8, 0, 1, r});
    dir.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0100, 0, 0, r});
    dir.push_back('{32'h8000_0000, 32'h8000_0000, 32'h0000_0100, 0, 0, r});
    dir.push_back('{32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 1, 0, r});
    dir.push_back('{32'h0000_1000, 32'h0000_1000, 32'h0000_0000, 0, 0, r});
    dir.push_back('{32'h0000_1000, 32'h0000_1000, 32'hffff_0000, 0, 0, r});
    dir.push_back('{32'h0000_1000, 32'h0000_1000, 32'h0000_0041, 0, 0, r});
    dir.push_back('{32'h0000_1000, 32'h0000_1000, 32'h0000_0042, 1, 0, r});
    dir.push_back('{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 0, 0, r});
    dir.push_back('{32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 1, 0, r});
    r = '0;
    r.box_done = 1;
    dir.push_back('{32'h1234_5678, 32'h0000_0000, 32'hffff_ffff, 1, 1, r});
    dir.push_back('{32'h0000_4000, 32'h0000_c000, 32'h0000_8000, 0, 0, r});
    dir.push_back('{32'hffff_4000, 32'hffff_c000, 32'h0002_0000, 1, 0, r});

    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir[i]) begin
      if (i == 2) begin
        wait_idle();
        write_reg(REG_ROW0_AB, {32'd0, ONE});
        write_reg(REG_ROW1_AB, {ONE, 32'd0});
        write_reg(REG_ROWW_CD, {32'd0, ONE});
        cfg_we <= 0;
      end
      if (i == 13) begin
        wait_idle();
        write_reg(REG_SCREEN, 64'd0);
        write_reg(REG_NEAR, 64'd0);
        cfg_we <= 0;
      end
      send_point(dir[i].x, dir[i].y, dir[i].z, dir[i].last, dir[i].typed, dir[i].res);
    end

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      random_setting();
      cfg_we <= 0;
      n = 0;
      while (n < 250) begin
        int len;
        len = $urandom_range(1, 8);
        if (phase == 5 && n >= 100) quiet = 1;
        for (int k = 0; k < len; k++) begin
          r = '0;
          if ($urandom_range(0, 9) == 0)
            send_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), 0, r);
          else
            send_point(rand_coord(), rand_coord(),
                       $urandom_range(0, 32'h0020_0000) - 32'h0002_0000,
                       k == len - 1, 0, r);
          n++;
        end
      end
    end

    s_axis_tvalid <= 0;
    wait (pending_pixels.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
